// ===== rtl/smo_pkg.sv =====
// ============================================================================
// smo_pkg
// constants and types shared by the scalar modulo-order alu
// ============================================================================
package smo_pkg;

    typedef enum logic [1:0] {
        KIND_SUB    = 2'd0,
        KIND_HALF   = 2'd1,
        KIND_RANGE  = 2'd2,
        KIND_REDUCE = 2'd3
    } kind_t;

    // r0 where r = 2^254 - r0
    localparam logic [127:0] R0     = 128'h62F36CF0ABF873ACE0AD37518B27BADB;
    localparam logic [255:0] R_MOD  =
        256'h3FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF9D0C930F54078C531F52C8AE74D84525;
    localparam logic [255:0] R_HALF =
        256'h1FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFCE864987AA03C6298FA964573A6C2293;
    localparam logic [255:0] R_X8   =
        256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFCE864987AA03C6298FA964573A6C22928;

endpackage

// ===== rtl/smo_mul64.sv =====
// ============================================================================
// smo_mul64
// registered 64x64 multiplier built from four 32x32 partial products
// ============================================================================
module smo_mul64
(
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  x,
    input  logic [63:0]  y,
    output logic [127:0] p
);
    logic [63:0] pp_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0] <= 64'(x[31:0])  * 64'(y[31:0]);
            pp_reg[1] <= 64'(x[31:0])  * 64'(y[63:32]);
            pp_reg[2] <= 64'(x[63:32]) * 64'(y[31:0]);
            pp_reg[3] <= 64'(x[63:32]) * 64'(y[63:32]);
        end
    end

    assign p = {64'd0, pp_reg[0]} + {32'd0, pp_reg[1], 32'd0}
             + {32'd0, pp_reg[2], 32'd0} + {pp_reg[3], 64'd0};
endmodule

// ===== rtl/scalar_mod_order_alu_unit.sv =====
// ============================================================================
// scalar_mod_order_alu_unit
// pipelined alu for scalars modulo the group order r = 2^254 - r0
// ============================================================================
// One transaction carries one operation (subtract, halve, range check, or
// reduce of a 384-bit value) and gives one result transaction. The unit is a
// six-stage pipeline: a new transaction is taken every cycle while in_stall is
// low, and its result moves through the stage registers to the output. The
// depth is set by the fold multiplies: the 128x128 product of the wide top by
// r0 and the small fold of bits above 253 by r0 each run through registered
// 64x64 partial-product multipliers. A stall freezes the whole pipeline, and
// the last stage holds its result until it is taken.
module scalar_mod_order_alu_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  smo_pkg::kind_t      kind,
    input  logic [63:0]         a_w0,
    input  logic [63:0]         a_w1,
    input  logic [63:0]         a_w2,
    input  logic [63:0]         a_w3,
    input  logic [63:0]         a_w4,
    input  logic [63:0]         a_w5,
    input  logic [63:0]         b_w0,
    input  logic [63:0]         b_w1,
    input  logic [63:0]         b_w2,
    input  logic [63:0]         b_w3,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [63:0]         d_w0,
    output logic [63:0]         d_w1,
    output logic [63:0]         d_w2,
    output logic [63:0]         d_w3,
    output logic                in_range
);
    import smo_pkg::*;

    localparam int Depth = 6;

    // advance when the last stage is empty or being taken
    logic adv;
    logic [Depth-1:0] vld_reg;
    assign adv      = !vld_reg[Depth-1] || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
    end

    // ---------------- stage 1: subtract / halve / range, wide mul issue
    kind_t        k1_reg, k2_reg, k3_reg, k4_reg, k5_reg;
    logic [256:0] t1_reg;      // 257-bit pre-fold value (bit 256 only for sub)
    logic         inr1_reg, inr2_reg, inr3_reg, inr4_reg, inr5_reg;
    logic [255:0] a_lo1_reg;

    logic [255:0] a_in, b_in;
    logic [256:0] diff, sub_t, half_t, t1_next;
    logic [256:0] rng;
    assign a_in = {a_w3, a_w2, a_w1, a_w0};
    assign b_in = {b_w3, b_w2, b_w1, b_w0};
    assign diff = {1'b0, a_in} - {1'b0, b_in};
    assign rng  = {1'b0, a_in} - {1'b0, R_MOD};
    // sum is taken modulo 2^257 so the carry of the 8r add lands in bit 256
    assign sub_t  = {1'b0, diff[255:0]} + (diff[256] ? {1'b0, R_X8} : 257'd0);
    assign half_t = {2'b00, a_in[255:1]} + (a_in[0] ? {1'b0, R_HALF} : 257'd0);

    always_comb
    begin
        case (kind)
            KIND_SUB:  t1_next = sub_t;
            KIND_HALF: t1_next = half_t;
            default:   t1_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k1_reg    <= kind;
            t1_reg    <= t1_next;
            inr1_reg  <= (kind == KIND_RANGE) && rng[256];
            a_lo1_reg <= a_in;
        end
    end

    // wide top times r0: four 64x64 products, registered at stage 1
    logic [127:0] w00, w01, w10, w11;
    smo_mul64 u_m00 (.clk(clk), .en(adv), .x(a_w4), .y(R0[63:0]),   .p(w00));
    smo_mul64 u_m01 (.clk(clk), .en(adv), .x(a_w4), .y(R0[127:64]), .p(w01));
    smo_mul64 u_m10 (.clk(clk), .en(adv), .x(a_w5), .y(R0[63:0]),   .p(w10));
    smo_mul64 u_m11 (.clk(clk), .en(adv), .x(a_w5), .y(R0[127:64]), .p(w11));

    // ---------------- stage 2: sum the wide product
    logic [255:0] prod2_reg, a_lo2_reg;
    logic [256:0] t2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k2_reg    <= k1_reg;
            inr2_reg  <= inr1_reg;
            t2_reg    <= t1_reg;
            a_lo2_reg <= a_lo1_reg;
            prod2_reg <= {128'd0, w00} + {64'd0, w01, 64'd0}
                       + {64'd0, w10, 64'd0} + {w11, 128'd0};
        end
    end

    // ---------------- stage 3: 4*prod + a_lo for reduce; pick value
    logic [257:0] wsum;
    logic [257:0] v3_reg;
    assign wsum = {prod2_reg, 2'b00} + {2'b00, a_lo2_reg};
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k3_reg   <= k2_reg;
            inr3_reg <= inr2_reg;
            v3_reg   <= (k2_reg == KIND_REDUCE) ? wsum : {1'b0, t2_reg};
        end
    end

    // ---------------- stage 4: fold top bits (at most 4 bits) times r0
    logic [3:0]   top3;
    logic [127:0] f0, f1;
    logic [253:0] low4_reg;
    assign top3 = v3_reg[257:254];
    smo_mul64 u_f0 (.clk(clk), .en(adv), .x({60'd0, top3}), .y(R0[63:0]),   .p(f0));
    smo_mul64 u_f1 (.clk(clk), .en(adv), .x({60'd0, top3}), .y(R0[127:64]), .p(f1));
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k4_reg   <= k3_reg;
            inr4_reg <= inr3_reg;
            low4_reg <= v3_reg[253:0];
        end
    end

    // ---------------- stage 5: partial reduction sum (below 2r)
    logic [255:0] s5_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k5_reg   <= k4_reg;
            inr5_reg <= inr4_reg;
            s5_reg   <= {2'b00, low4_reg} + {64'd0, f1, 64'd0} + {128'd0, f0};
        end
    end

    // ---------------- stage 6: conditional subtract of r, output register
    logic [256:0] fin;
    logic [255:0] d_reg;
    logic         inr_reg;
    assign fin = {1'b0, s5_reg} - {1'b0, R_MOD};
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inr_reg <= inr5_reg;
            if (k5_reg == KIND_RANGE)
                d_reg <= '0;
            else
                d_reg <= fin[256] ? s5_reg : fin[255:0];
        end
    end

    assign out_valid = vld_reg[Depth-1];
    assign d_w0      = d_reg[63:0];
    assign d_w1      = d_reg[127:64];
    assign d_w2      = d_reg[191:128];
    assign d_w3      = d_reg[255:192];
    assign in_range  = inr_reg;
endmodule

// ===== rtl/smo_checker.sv =====
// ============================================================================
// smo_checker
// port-level checks for the scalar modulo-order alu
// ============================================================================
module smo_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] d_w3,
    input logic        in_range
);
    // result always below 2^254
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> d_w3[63:62] == 2'b00)
        else $error("result not reduced");

    // range flag only with a zero top result word
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_range) |-> d_w3 == 64'd0)
        else $error("range flag with nonzero result");

    // input stalls only while output is stalled
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stall without output stall");

    // stalled result stays valid and its top word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && out_stall) |-> (out_valid && $stable(d_w3)))
        else $error("stalled result changed");
endmodule

bind scalar_mod_order_alu_unit smo_checker u_smo_checker
(
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .d_w3(d_w3),
    .in_range(in_range)
);

// ===== dv/scalar_mod_order_alu_checker.sv =====
// ============================================================================
// scalar_mod_order_alu_checker
// predicts and checks every result transaction of the scalar alu
// ============================================================================
// Each accepted input transaction is turned into an expected result by
// exact wide arithmetic modulo r. Accepted results are compared against
// the oldest expectation.
module scalar_mod_order_alu_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  smo_pkg::kind_t kind,
    input  logic [63:0]    a_w0,
    input  logic [63:0]    a_w1,
    input  logic [63:0]    a_w2,
    input  logic [63:0]    a_w3,
    input  logic [63:0]    a_w4,
    input  logic [63:0]    a_w5,
    input  logic [63:0]    b_w0,
    input  logic [63:0]    b_w1,
    input  logic [63:0]    b_w2,
    input  logic [63:0]    b_w3,
    input  logic           out_valid,
    input  logic           out_stall,
    input  logic [63:0]    d_w0,
    input  logic [63:0]    d_w1,
    input  logic [63:0]    d_w2,
    input  logic [63:0]    d_w3,
    input  logic           in_range,
    output int             pending,
    output int             fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import smo_pkg::*;

    typedef struct {
        logic [255:0] d;
        logic         in_range;
    } scalar_result_t;

    scalar_result_t result_q[$];

    function automatic scalar_result_t scalar_mod_r(kind_t k, logic [383:0] a,
                                                    logic [255:0] b);
        scalar_result_t res;
        logic [511:0] x;
        logic [511:0] r_wide;
        r_wide = {256'd0, R_MOD};
        res.d = '0;
        res.in_range = 1'b0;
        case (k)
            KIND_SUB:
            begin
                // a - b + 8r is never negative and congruent to a - b
                x = {256'd0, a[255:0]} + (r_wide << 3) - {256'd0, b};
                x = x % r_wide;
                res.d = x[255:0];
            end
            KIND_HALF:
            begin
                x = {256'd0, a[255:0]} >> 1;
                if (a[0])
                    x = x + {256'd0, R_HALF};
                x = x % r_wide;
                res.d = x[255:0];
            end
            KIND_RANGE:
                res.in_range = (a[255:0] < R_MOD);
            default:
            begin
                x = {128'd0, a} % r_wide;
                res.d = x[255:0];
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scalar_result_t exp_res;
        if (!rst_n)
        begin
            result_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                result_q.push_back(scalar_mod_r(kind, {a_w5, a_w4, a_w3, a_w2, a_w1, a_w0},
                                                {b_w3, b_w2, b_w1, b_w0}));
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_res = result_q.pop_front();
                    if (exp_res.d[63:0] !== d_w0)
                    begin
                        $error("d_w0 expected %h actual %h", exp_res.d[63:0], d_w0);
                        fail_count++;
                    end
                    if (exp_res.d[127:64] !== d_w1)
                    begin
                        $error("d_w1 expected %h actual %h", exp_res.d[127:64], d_w1);
                        fail_count++;
                    end
                    if (exp_res.d[191:128] !== d_w2)
                    begin
                        $error("d_w2 expected %h actual %h", exp_res.d[191:128], d_w2);
                        fail_count++;
                    end
                    if (exp_res.d[255:192] !== d_w3)
                    begin
                        $error("d_w3 expected %h actual %h", exp_res.d[255:192], d_w3);
                        fail_count++;
                    end
                    if (exp_res.in_range !== in_range)
                    begin
                        $error("in_range expected %b actual %b", exp_res.in_range, in_range);
                        fail_count++;
                    end
                end
            end
            pending = result_q.size();
        end
    end

endmodule

// ===== dv/tb_scalar_mod_order_alu_unit.sv =====
// ============================================================================
// tb_scalar_mod_order_alu_unit
// stimulus and verdict for the scalar modulo-order alu
// ============================================================================
// Directed operands at the edges of the range, then random operations with
// operands biased toward r and its multiples. Both sides idle at random;
// the checker module predicts and compares every result.
module tb_scalar_mod_order_alu_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import smo_pkg::*;

    localparam int NUM_RANDOM   = 630;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    kind_t       kind;
    logic [63:0] a_w0, a_w1, a_w2, a_w3, a_w4, a_w5;
    logic [63:0] b_w0, b_w1, b_w2, b_w3;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] d_w0, d_w1, d_w2, d_w3;
    logic        in_range;
    int          pending;
    int          fail_count;
    int          idle_cycles;

    scalar_mod_order_alu_unit dut (.*);
    scalar_mod_order_alu_checker checker_i (.*);

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // watchdog: cycles in which neither channel moves a transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // one 64-bit limb, biased to the extremes
    function automatic logic [63:0] pick_limb();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'($urandom_range(0, 7));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // 256-bit operand: random limbs, or close to r, 2r or 8r mod 2^256
    function automatic logic [255:0] pick_scalar();
        logic [255:0] s;
        logic [255:0] delta;
        delta = 256'($urandom_range(0, 8));
        case ($urandom_range(0, 7))
            0: s = R_MOD + delta - 256'd4;
            1: s = (R_MOD << 1) + delta - 256'd4;
            2: s = R_X8 + delta - 256'd4;
            3: s = {64'($urandom), pick_limb(), pick_limb(), pick_limb()};
            default: s = {pick_limb(), pick_limb(), pick_limb(), pick_limb()};
        endcase
        return s;
    endfunction

    // present one transaction after the given gap and wait for acceptance
    task automatic send_op(kind_t k, logic [383:0] a, logic [255:0] b, int gap);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        kind <= k;
        {a_w5, a_w4, a_w3, a_w2, a_w1, a_w0} <= a;
        {b_w3, b_w2, b_w1, b_w0} <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // receiver: random stall before each result, one long hold-off
    initial
    begin
        int taken;
        int g;
        taken = 0;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            g = (taken == 150) ? 60 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
            repeat (g)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [255:0] big;
        int gap;
        in_valid = 1'b0;
        kind = KIND_SUB;
        {a_w5, a_w4, a_w3, a_w2, a_w1, a_w0} = '0;
        {b_w3, b_w2, b_w1, b_w0} = '0;
        @(posedge rst_n);
        big = '1;

        // directed: extremes, every operation, borrow, odd halve, r itself
        send_op(KIND_SUB, '0, '0, 0);
        send_op(KIND_SUB, {128'd0, big}, '0, 0);
        send_op(KIND_SUB, '0, big, 0);
        send_op(KIND_SUB, 384'd1, 256'd2, 1);
        send_op(KIND_SUB, {128'd0, R_MOD}, R_MOD, 0);
        send_op(KIND_SUB, {128'd0, R_MOD}, 256'd1, 0);
        send_op(KIND_SUB, '1, '1, 2);
        send_op(KIND_HALF, '0, '0, 0);
        send_op(KIND_HALF, 384'd1, '0, 0);
        send_op(KIND_HALF, {128'd0, big}, '0, 0);
        send_op(KIND_HALF, {128'd0, R_MOD - 256'd1}, '0, 0);
        send_op(KIND_HALF, {128'd0, R_MOD}, big, 0);
        send_op(KIND_RANGE, '0, '0, 0);
        send_op(KIND_RANGE, {128'd0, R_MOD - 256'd1}, '0, 0);
        send_op(KIND_RANGE, {128'd0, R_MOD}, '0, 0);
        send_op(KIND_RANGE, '1, '1, 0);
        send_op(KIND_REDUCE, '0, '0, 0);
        send_op(KIND_REDUCE, '1, '1, 0);
        send_op(KIND_REDUCE, {128'd0, R_MOD}, '0, 0);
        send_op(KIND_REDUCE, {128'd0, R_MOD - 256'd1}, '0, 3);
        send_op(KIND_REDUCE, {128'd1, 256'd0}, '0, 0);
        send_op(KIND_REDUCE, {{128{1'b1}}, 256'd0}, '0, 0);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            // sender pause until the pipeline has drained
            if (n == 300)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            // bursts without gaps on some stretches, random gaps elsewhere
            gap = ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, 6);
            send_op(kind_t'($urandom_range(0, 3)),
                    {pick_limb(), pick_limb(), pick_scalar()}, pick_scalar(), gap);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== scalar_mod_order_alu_unit.f =====
rtl/smo_pkg.sv
rtl/smo_mul64.sv
rtl/scalar_mod_order_alu_unit.sv
rtl/smo_checker.sv
dv/scalar_mod_order_alu_checker.sv
dv/tb_scalar_mod_order_alu_unit.sv
